>>> rtl/ldfr_pkg.sv
// ----------------------------------------------------------------------------
// ldfr_pkg: shared types and constants for the led digit frame refresh block
// Command codes, state encoding, control and status bundles between the
// controller and the datapath, and the driver count clamp.
// ----------------------------------------------------------------------------
package ldfr_pkg;

  // store geometry
  localparam int MAX_DRIVERS = 4;
  localparam int ROWS        = 8;
  localparam int ROW_W       = $clog2(ROWS);
  localparam int STORE_DEPTH = 2 * ROWS * MAX_DRIVERS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int FCNT_W      = $clog2(STORE_DEPTH + 1);
  localparam int NDRV_W      = 3;
  localparam int DRV_W       = 2;

  // input commands
  typedef enum logic [2:0] {
    CMD_SET     = 3'd0,
    CMD_OR      = 3'd1,
    CMD_XOR     = 3'd2,
    CMD_FILL    = 3'd3,
    CMD_FLIP    = 3'd4,
    CMD_REFRESH = 3'd5,
    CMD_BCAST   = 3'd6
  } cmd_t;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_SKIP  = 2'd2;

  // result kinds
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_WORD   = 1'b1;

  // store write data source
  typedef enum logic [1:0] {
    WR_SET,
    WR_RMW,
    WR_FILL
  } wr_mode_t;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_RMW,
    S_FILL,
    S_STATUS,
    S_REF_RD,
    S_REF_WR,
    S_BCAST
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic       req_ready;
    logic       wr_en;
    wr_mode_t   wr_mode;
    logic       rd_ref;
    logic       flip;
    logic       clr_dirty;
    logic       code_we;
    logic [1:0] code;
    logic       fill_init;
    logic       fill_step;
    logic       ref_init;
    logic       ref_next;
    logic       bcast_init;
    logic       bcast_next;
    logic       load_status;
    logic       load_ref;
    logic       load_bcast;
  } ctl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic req_valid;
    cmd_t cmd;
    logic addr_bad;
    logic dirty;
    logic refresh_now;
    logic fill_done;
    logic drv_zero;
    logic row_last;
    logic can_load;
  } dp_stat_t;

  // driver count actually used: zero acts as one, large values saturate
  function automatic logic [NDRV_W-1:0] drivers_used(input logic [NDRV_W-1:0] n);
    logic [NDRV_W-1:0] r;
    r = n;
    if (n == '0) r = NDRV_W'(1);
    else if (n > NDRV_W'(MAX_DRIVERS)) r = NDRV_W'(MAX_DRIVERS);
    return r;
  endfunction

endpackage

>>> rtl/ldfr_req_if.sv
// ----------------------------------------------------------------------------
// ldfr_req_if: command channel
// Valid/ready channel carrying one command word.
// ----------------------------------------------------------------------------
interface ldfr_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] cmd;
  logic [5:0] digit_addr;
  logic [7:0] value;
  logic       both_buffers;
  logic       refresh_now;
  logic [3:0] reg_code;

  modport source (
    output valid, cmd, digit_addr, value, both_buffers, refresh_now, reg_code,
    input  ready
  );
  modport sink (
    input  valid, cmd, digit_addr, value, both_buffers, refresh_now, reg_code,
    output ready
  );
endinterface

>>> rtl/ldfr_rsp_if.sv
// ----------------------------------------------------------------------------
// ldfr_rsp_if: result channel
// Valid/ready channel carrying status words and serial driver words.
// ----------------------------------------------------------------------------
interface ldfr_rsp_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [1:0] status;
  logic [1:0] driver_index;
  logic [3:0] spi_register;
  logic [7:0] spi_data;
  logic       frame_end;
  logic       last;

  modport source (
    output valid, kind, status, driver_index, spi_register, spi_data, frame_end, last,
    input  ready
  );
  modport sink (
    input  valid, kind, status, driver_index, spi_register, spi_data, frame_end, last,
    output ready
  );
endinterface

>>> rtl/ldfr_cfg_if.sv
// ----------------------------------------------------------------------------
// ldfr_cfg_if: configuration write channel
// Valid/ready channel carrying the driver count register write data.
// ----------------------------------------------------------------------------
interface ldfr_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

>>> rtl/ldfr_ctrl.sv
// ----------------------------------------------------------------------------
// ldfr_ctrl: command sequencer
// State machine that decodes each accepted command and steps the datapath
// through digit writes, fill sweeps, refresh frames and broadcasts.
// ----------------------------------------------------------------------------
module ldfr_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  ldfr_pkg::dp_stat_t   stat,
  output ldfr_pkg::ctl_cmd_t   ctl
);
  import ldfr_pkg::*;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (stat.req_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        case (stat.cmd)
          CMD_SET: state_next = S_STATUS;
          CMD_OR, CMD_XOR: state_next = stat.addr_bad ? S_STATUS : S_RMW;
          CMD_FILL: state_next = S_FILL;
          CMD_FLIP: state_next = stat.refresh_now ? S_REF_RD : S_STATUS;
          CMD_REFRESH: state_next = stat.dirty ? S_REF_RD : S_STATUS;
          CMD_BCAST: state_next = S_BCAST;
          default: state_next = S_STATUS;
        endcase
      end
      S_RMW: state_next = S_STATUS;
      S_FILL: begin
        if (stat.fill_done) state_next = S_STATUS;
      end
      S_STATUS: begin
        if (stat.can_load) state_next = S_IDLE;
      end
      S_REF_RD: state_next = S_REF_WR;
      S_REF_WR: begin
        if (stat.can_load) begin
          state_next = (stat.drv_zero && stat.row_last) ? S_IDLE : S_REF_RD;
        end
      end
      S_BCAST: begin
        if (stat.can_load && stat.drv_zero) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    ctl = '0;
    ctl.wr_mode = WR_SET;
    ctl.code = ST_OK;
    case (state)
      S_IDLE: ctl.req_ready = 1'b1;
      S_DECODE: begin
        case (stat.cmd)
          CMD_SET, CMD_OR, CMD_XOR: begin
            if (stat.addr_bad) begin
              ctl.code_we = 1'b1;
              ctl.code = ST_RANGE;
            end else if (stat.cmd == CMD_SET) begin
              ctl.wr_en = 1'b1;
              ctl.code_we = 1'b1;
            end
          end
          CMD_FILL: ctl.fill_init = 1'b1;
          CMD_FLIP: begin
            ctl.flip = 1'b1;
            if (stat.refresh_now) ctl.ref_init = 1'b1;
            else ctl.code_we = 1'b1;
          end
          CMD_REFRESH: begin
            if (stat.dirty) begin
              ctl.ref_init = 1'b1;
            end else begin
              ctl.code_we = 1'b1;
              ctl.code = ST_SKIP;
            end
          end
          CMD_BCAST: ctl.bcast_init = 1'b1;
          default: ctl.code_we = 1'b1;
        endcase
      end
      S_RMW: begin
        ctl.wr_en = 1'b1;
        ctl.wr_mode = WR_RMW;
        ctl.code_we = 1'b1;
      end
      S_FILL: begin
        ctl.wr_en = 1'b1;
        ctl.wr_mode = WR_FILL;
        ctl.fill_step = 1'b1;
        ctl.code_we = stat.fill_done;
      end
      S_STATUS: ctl.load_status = stat.can_load;
      S_REF_RD: ctl.rd_ref = 1'b1;
      S_REF_WR: begin
        ctl.rd_ref = 1'b1;
        if (stat.can_load) begin
          ctl.load_ref = 1'b1;
          ctl.ref_next = 1'b1;
          ctl.clr_dirty = stat.drv_zero && stat.row_last;
        end
      end
      S_BCAST: begin
        if (stat.can_load) begin
          ctl.load_bcast = 1'b1;
          ctl.bcast_next = 1'b1;
        end
      end
      default: ctl = '0;
    endcase
  end

`ifndef NO_ASSERTIONS
  // a new command is only taken once the previous one has fully finished
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    ctl.req_ready |-> !(ctl.wr_en || ctl.load_status || ctl.load_ref || ctl.load_bcast))
    else $error("command taken while work is in progress");

  // at most one result is produced per cycle
  a_one_load: assert property (@(posedge clk) disable iff (rst)
    $onehot0({ctl.load_status, ctl.load_ref, ctl.load_bcast}))
    else $error("more than one result loaded");

  // a result is never loaded over one that is still waiting
  a_load_room: assert property (@(posedge clk) disable iff (rst)
    (ctl.load_status || ctl.load_ref || ctl.load_bcast) |-> stat.can_load)
    else $error("result loaded while output is full");

  // a refresh word always follows a read cycle of the same word
  a_ref_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_REF_WR) |-> ($past(state) == S_REF_RD || $past(state) == S_REF_WR))
    else $error("refresh word without a store read");
`endif
endmodule

>>> rtl/ldfr_datapath.sv
// ----------------------------------------------------------------------------
// ldfr_datapath: frame store and result register
// Double-buffered segment store with reset valid bits, command field
// latches, fill and frame counters, config register and the output word.
// ----------------------------------------------------------------------------
module ldfr_datapath (
  input  logic                 clk,
  input  logic                 rst,
  ldfr_req_if.sink             req,
  ldfr_rsp_if.source           rsp,
  ldfr_cfg_if.sink             cfg,
  input  ldfr_pkg::ctl_cmd_t   ctl,
  output ldfr_pkg::dp_stat_t   stat
);
  import ldfr_pkg::*;

  // segment store and per-entry valid bits
  logic [7:0]             mem [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] valid;
  logic [7:0]             rdata;
  logic                   rvalid;

  // latched command fields
  logic [2:0]        cmd;
  logic [ADDR_W-1:0] addr;
  logic [7:0]        val;
  logic              both;
  logic              now;
  logic [3:0]        reg_code;

  // control registers
  logic              write_half;
  logic              dirty;
  logic [NDRV_W-1:0] num_drivers;
  logic [1:0]        code;

  // sweep counters
  logic [FCNT_W-1:0] fill_cnt;
  logic [ROW_W-1:0]  row;
  logic [DRV_W-1:0]  drv;

  // output word
  logic       o_valid;
  logic       o_kind;
  logic [1:0] o_status;
  logic [1:0] o_drv;
  logic [3:0] o_reg;
  logic [7:0] o_data;
  logic       o_fend;
  logic       o_last;

  logic [NDRV_W-1:0] n_used;
  logic [DRV_W-1:0]  drv_top;
  logic [ADDR_W-1:0] digits;
  logic [ADDR_W-1:0] wr_base;
  logic [ADDR_W-1:0] show_base;
  logic [ADDR_W-1:0] wr_idx;
  logic [ADDR_W-1:0] ref_idx;
  logic [ADDR_W-1:0] fill_idx;
  logic [FCNT_W-1:0] fill_len;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;
  logic [7:0]        old;
  logic              can_load;

  // layout of the two halves for the current driver count
  always_comb begin
    n_used    = drivers_used(num_drivers);
    drv_top   = DRV_W'(n_used - NDRV_W'(1));
    digits    = ADDR_W'(n_used) << ROW_W;
    wr_base   = write_half ? digits : '0;
    show_base = write_half ? '0 : digits;
    wr_idx    = wr_base + addr;
    ref_idx   = show_base + ADDR_W'({drv, row});
    fill_idx  = (both ? '0 : wr_base) + fill_cnt[ADDR_W-1:0];
    fill_len  = both ? (FCNT_W'(digits) << 1) : FCNT_W'(digits);
    rd_addr   = ctl.rd_ref ? ref_idx : wr_idx;
    old       = rvalid ? rdata : 8'h00;
  end

  // store write data
  always_comb begin
    wr_addr = wr_idx;
    wr_data = val;
    case (ctl.wr_mode)
      WR_SET: wr_data = val;
      WR_RMW: wr_data = (cmd == CMD_OR) ? (old | val) : (old ^ val);
      WR_FILL: begin
        wr_addr = fill_idx;
        wr_data = val;
      end
      default: wr_data = val;
    endcase
  end

  // store array, registered read
  always_ff @(posedge clk) begin
    if (ctl.wr_en) mem[wr_addr] <= wr_data;
    rdata <= mem[rd_addr];
  end

  // valid bits: unwritten entries read as zero after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      rvalid <= 1'b0;
    end else begin
      if (ctl.wr_en) valid[wr_addr] <= 1'b1;
      rvalid <= valid[rd_addr];
    end
  end

  // command field capture
  assign req.ready = ctl.req_ready;

  always_ff @(posedge clk) begin
    if (req.valid && ctl.req_ready) begin
      cmd      <= req.cmd;
      addr     <= req.digit_addr;
      val      <= req.value;
      both     <= req.both_buffers;
      now      <= req.refresh_now;
      reg_code <= req.reg_code;
    end
  end

  // config register, half select and dirty flag
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_drivers <= NDRV_W'(MAX_DRIVERS);
      write_half  <= 1'b1;
      dirty       <= 1'b0;
    end else begin
      if (cfg.valid) num_drivers <= cfg.data;
      if (ctl.flip) begin
        write_half <= ~write_half;
        dirty      <= 1'b1;
      end else if (ctl.clr_dirty) begin
        dirty <= 1'b0;
      end
    end
  end

  // pending status code
  always_ff @(posedge clk) begin
    if (ctl.code_we) code <= ctl.code;
  end

  // fill and frame counters
  always_ff @(posedge clk) begin
    if (ctl.fill_init) fill_cnt <= '0;
    else if (ctl.fill_step) fill_cnt <= fill_cnt + FCNT_W'(1);

    if (ctl.ref_init) begin
      row <= '0;
      drv <= drv_top;
    end else if (ctl.ref_next) begin
      if (drv == '0) begin
        row <= row + ROW_W'(1);
        drv <= drv_top;
      end else begin
        drv <= drv - DRV_W'(1);
      end
    end else if (ctl.bcast_init) begin
      drv <= drv_top;
    end else if (ctl.bcast_next) begin
      drv <= drv - DRV_W'(1);
    end
  end

  // output word register
  assign can_load = !o_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (ctl.load_status || ctl.load_ref || ctl.load_bcast) begin
      o_valid <= 1'b1;
    end else if (rsp.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_status) begin
      o_kind   <= KIND_STATUS;
      o_status <= code;
      o_drv    <= '0;
      o_reg    <= '0;
      o_data   <= '0;
      o_fend   <= 1'b0;
      o_last   <= 1'b1;
    end else if (ctl.load_ref) begin
      o_kind   <= KIND_WORD;
      o_status <= ST_OK;
      o_drv    <= drv;
      o_reg    <= 4'(row) + 4'd1;
      o_data   <= old;
      o_fend   <= (drv == '0);
      o_last   <= (drv == '0) && (row == ROW_W'(ROWS - 1));
    end else if (ctl.load_bcast) begin
      o_kind   <= KIND_WORD;
      o_status <= ST_OK;
      o_drv    <= drv;
      o_reg    <= reg_code;
      o_data   <= val;
      o_fend   <= (drv == '0);
      o_last   <= (drv == '0);
    end
  end

  assign rsp.valid        = o_valid;
  assign rsp.kind         = o_kind;
  assign rsp.status       = o_status;
  assign rsp.driver_index = o_drv;
  assign rsp.spi_register = o_reg;
  assign rsp.spi_data     = o_data;
  assign rsp.frame_end    = o_fend;
  assign rsp.last         = o_last;

  // status back to the controller
  always_comb begin
    stat.req_valid   = req.valid;
    stat.cmd         = cmd_t'(cmd);
    stat.addr_bad    = (addr >= digits);
    stat.dirty       = dirty;
    stat.refresh_now = now;
    stat.fill_done   = (fill_cnt == fill_len - FCNT_W'(1));
    stat.drv_zero    = (drv == '0);
    stat.row_last    = (row == ROW_W'(ROWS - 1));
    stat.can_load    = can_load;
  end

`ifndef NO_ASSERTIONS
  // store is never written at an out of range digit address
  a_no_bad_write: assert property (@(posedge clk) disable iff (rst)
    (ctl.wr_en && ctl.wr_mode != WR_FILL) |-> (addr < digits))
    else $error("store written with rejected address");

  // refresh reads stay inside the shown half
  a_ref_in_half: assert property (@(posedge clk) disable iff (rst)
    ctl.load_ref |-> (drv <= drv_top))
    else $error("refresh driver index beyond chain");

  // the dirty flag is cleared only by the final word of a refresh
  a_dirty_clear: assert property (@(posedge clk) disable iff (rst)
    ctl.clr_dirty |-> (ctl.load_ref && drv == '0 && row == ROW_W'(ROWS - 1)))
    else $error("dirty cleared outside the last refresh word");
`endif
endmodule

>>> rtl/led_digit_frame_refresh_controller.sv
// ----------------------------------------------------------------------------
// led_digit_frame_refresh_controller: double-buffered segment frame driver
// Top level joining the command sequencer and the frame store datapath.
// ----------------------------------------------------------------------------
// Usage:
// - req carries one command word per handshake; rsp returns status words or
//   serial driver words (register code and data byte), last marks the final
//   word caused by a command; cfg writes the chained driver count.
// - a command is taken only while the sequencer is idle; the next command
//   can be taken while its final result still waits in the output register.
// - set: decode with store write, then status load; or/xor: read, modify,
//   then write to the store; fill: one store entry per cycle, 8 or 16
//   entries per driver.
// - refresh: each serial word takes a store read then an output load, for
//   8 * drivers words; broadcast: one word per cycle after decode while
//   the output register can take it.
// - reset clears the store through per-entry valid bits at once, selects the
//   second half for writing, clears dirty and sets the driver count to four.
// - when rsp stalls, the output register holds its word and the sequencer
//   waits; no word is dropped or repeated.
// ----------------------------------------------------------------------------
module led_digit_frame_refresh_controller (
  input  logic        clk,
  input  logic        rst,
  ldfr_req_if.sink    req,
  ldfr_rsp_if.source  rsp,
  ldfr_cfg_if.sink    cfg
);
  import ldfr_pkg::*;

  ctl_cmd_t ctl;
  dp_stat_t stat;

  // sequencer
  ldfr_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctl  (ctl)
  );

  // frame store and output
  ldfr_datapath u_datapath (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .rsp  (rsp),
    .cfg  (cfg),
    .ctl  (ctl),
    .stat (stat)
  );
endmodule

>>> tb/sv/tb_led_digit_frame_refresh_controller.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_led_digit_frame_refresh_controller: self-checking bench for the frame
// refresh controller
// Commands go in over the req channel and driver counts over cfg. A shadow
// copy of the frame store, the write half, the dirty flag and the driver count
// predicts every status and serial word, and each word taken from rsp is
// checked against the oldest prediction. Both sides stall in random bursts.
// ----------------------------------------------------------------------------
module tb_led_digit_frame_refresh_controller;
  import ldfr_pkg::*;

  // command code outside the defined set, the block answers with ok
  localparam logic [2:0] CMD_UNUSED    = 3'd7;
  localparam int         IDLE_MAX      = 7;
  localparam int         SETTLE_CYCLES = 20;
  localparam int         RUN_LIMIT_NS  = 10_000_000;

  // one word expected on rsp
  typedef struct packed {
    logic       kind;
    logic [1:0] status;
    logic [1:0] drv;
    logic [3:0] regc;
    logic [7:0] data;
    logic       fend;
    logic       last;
  } disp_word_t;

  logic clk = 1'b0;
  logic rst;

  ldfr_req_if req ();
  ldfr_rsp_if rsp ();
  ldfr_cfg_if cfg ();

  led_digit_frame_refresh_controller u_top (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cfg (cfg)
  );

  // shadow of the block state
  logic [7:0] shadow_store [STORE_DEPTH];
  logic       shadow_wr_half;
  logic       shadow_dirty;
  logic [2:0] shadow_ndrv;

  disp_word_t pending_words [$];
  int         errors  = 0;
  bit         idle_on = 1'b1;

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // run limit
  initial begin
    #(RUN_LIMIT_NS);
    $display("RESULT: ERROR");
    $finish;
  end

  // driver count in use: zero acts as one, large values saturate
  function automatic int unsigned used_drivers(input logic [2:0] n);
    if (n == 3'd0) return 1;
    if (n > 3'(MAX_DRIVERS)) return MAX_DRIVERS;
    return n;
  endfunction

  function automatic void push_word(input logic kind, input logic [1:0] status,
                                    input logic [1:0] drv, input logic [3:0] regc,
                                    input logic [7:0] data, input logic fend,
                                    input logic last);
    disp_word_t w;
    w.kind   = kind;
    w.status = status;
    w.drv    = drv;
    w.regc   = regc;
    w.data   = data;
    w.fend   = fend;
    w.last   = last;
    pending_words.push_back(w);
  endfunction

  // refresh of the shown half: eight frames, highest driver first
  function automatic void push_refresh();
    int unsigned n, base, idx;
    int          row, d;
    n = used_drivers(shadow_ndrv);
    if (!shadow_dirty) begin
      push_word(KIND_STATUS, ST_SKIP, 2'd0, 4'd0, 8'd0, 1'b0, 1'b1);
      return;
    end
    base = int'(shadow_wr_half ^ 1'b1) * ROWS * n;
    for (row = 0; row < ROWS; row++) begin
      for (d = n; d > 0; d--) begin
        idx = (base + ROWS * (d - 1) + row) % STORE_DEPTH;
        push_word(KIND_WORD, ST_OK, 2'(d - 1), 4'(row + 1), shadow_store[idx],
                  d == 1, (d == 1) && (row == ROWS - 1));
      end
    end
    shadow_dirty = 1'b0;
  endfunction

  // update the shadow state for one accepted command and queue its words
  function automatic void apply_command(input logic [2:0] c, input logic [5:0] addr,
                                        input logic [7:0] val, input logic both,
                                        input logic now, input logic [3:0] regc);
    int unsigned n, digits, idx, start, len, i;
    n      = used_drivers(shadow_ndrv);
    digits = ROWS * n;
    case (c)
      CMD_SET, CMD_OR, CMD_XOR: begin
        if (addr >= digits) begin
          push_word(KIND_STATUS, ST_RANGE, 2'd0, 4'd0, 8'd0, 1'b0, 1'b1);
        end else begin
          idx = (int'(shadow_wr_half) * digits + addr) % STORE_DEPTH;
          if (c == CMD_SET) shadow_store[idx] = val;
          else if (c == CMD_OR) shadow_store[idx] = shadow_store[idx] | val;
          else shadow_store[idx] = shadow_store[idx] ^ val;
          push_word(KIND_STATUS, ST_OK, 2'd0, 4'd0, 8'd0, 1'b0, 1'b1);
        end
      end
      CMD_FILL: begin
        start = both ? 0 : int'(shadow_wr_half) * digits;
        len   = both ? 2 * digits : digits;
        for (i = 0; i < len; i++) shadow_store[(start + i) % STORE_DEPTH] = val;
        push_word(KIND_STATUS, ST_OK, 2'd0, 4'd0, 8'd0, 1'b0, 1'b1);
      end
      CMD_FLIP: begin
        shadow_wr_half = ~shadow_wr_half;
        shadow_dirty   = 1'b1;
        if (now) push_refresh();
        else push_word(KIND_STATUS, ST_OK, 2'd0, 4'd0, 8'd0, 1'b0, 1'b1);
      end
      CMD_REFRESH: push_refresh();
      CMD_BCAST: begin
        for (i = n; i > 0; i--) begin
          push_word(KIND_WORD, ST_OK, 2'(i - 1), regc, val, i == 1, i == 1);
        end
      end
      default: push_word(KIND_STATUS, ST_OK, 2'd0, 4'd0, 8'd0, 1'b0, 1'b1);
    endcase
  endfunction

  function automatic void check_field(input string name, input int unsigned exp_v,
                                      input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s expected %0d actual %0d", name, exp_v, act_v);
      errors++;
    end
  endfunction

  // result side: random stall bursts and word checking
  initial begin
    int         stall;
    disp_word_t exp_w;
    rsp.ready = 1'b0;
    stall     = 0;
    forever begin
      @(posedge clk);
      if (!rst && rsp.valid && rsp.ready) begin
        if (pending_words.size() == 0) begin
          $error("word on rsp with nothing expected");
          errors++;
        end else begin
          exp_w = pending_words.pop_front();
          check_field("kind", exp_w.kind, rsp.kind);
          check_field("status", exp_w.status, rsp.status);
          check_field("driver_index", exp_w.drv, rsp.driver_index);
          check_field("spi_register", exp_w.regc, rsp.spi_register);
          check_field("spi_data", exp_w.data, rsp.spi_data);
          check_field("frame_end", exp_w.fend, rsp.frame_end);
          check_field("last", exp_w.last, rsp.last);
        end
      end
      if (stall > 0) begin
        stall--;
        rsp.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        stall = $urandom_range(1, IDLE_MAX) - 1;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  // send one command word; valid stays high for a following word
  task automatic send_cmd(input logic [2:0] c, input logic [5:0] addr,
                          input logic [7:0] val, input logic both, input logic now,
                          input logic [3:0] regc);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, IDLE_MAX)) @(posedge clk);
    end
    req.valid        <= 1'b1;
    req.cmd          <= c;
    req.digit_addr   <= addr;
    req.value        <= val;
    req.both_buffers <= both;
    req.refresh_now  <= now;
    req.reg_code     <= regc;
    do @(posedge clk); while (!req.ready);
    apply_command(c, addr, val, both, now, regc);
  endtask

  // random command, mostly in-range digit writes, flips and refreshes
  task automatic send_random();
    logic [2:0]  c;
    logic [5:0]  addr;
    int unsigned pick, digits;
    digits = ROWS * used_drivers(shadow_ndrv);
    pick   = $urandom_range(0, 99);
    addr   = 6'($urandom_range(0, 63));
    c      = 3'($urandom_range(0, 7));
    if (pick < 40) begin
      c = 3'($urandom_range(0, 2));
      if ($urandom_range(0, 9) != 0) addr = 6'($urandom_range(0, digits - 1));
    end else if (pick < 47) c = CMD_FILL;
    else if (pick < 65) c = CMD_FLIP;
    else if (pick < 80) c = CMD_REFRESH;
    else if (pick < 95) c = CMD_BCAST;
    else if (pick < 98) c = CMD_UNUSED;
    send_cmd(c, addr, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
             1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
  endtask

  // stop sending and let every expected word come out
  task automatic wait_drain();
    req.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_driver_count(input logic [2:0] v);
    wait_drain();
    cfg.valid <= 1'b1;
    cfg.data  <= v;
    do @(posedge clk); while (!cfg.ready);
    shadow_ndrv = v;
    cfg.valid <= 1'b0;
  endtask

  // refresh right after reset is skipped, unknown command is ok
  task automatic test_reset_state();
    send_cmd(CMD_REFRESH, 6'd0, 8'd0, 1'b0, 1'b0, 4'd0);
    send_cmd(CMD_UNUSED, 6'd63, 8'hff, 1'b1, 1'b1, 4'hf);
  endtask

  // set, or, xor at both ends of the range and beyond it
  task automatic test_digit_writes();
    send_cmd(CMD_SET, 6'd0, 8'hff, 1'b0, 1'b0, 4'd0);
    send_cmd(CMD_SET, 6'd31, 8'ha5, 1'b1, 1'b1, 4'hf);
    send_cmd(CMD_OR, 6'd5, 8'h0f, 1'b0, 1'b0, 4'd0);
    send_cmd(CMD_XOR, 6'd5, 8'hff, 1'b0, 1'b0, 4'd0);
    send_cmd(CMD_XOR, 6'd31, 8'h5a, 1'b0, 1'b0, 4'd0);
    send_cmd(CMD_SET, 6'd32, 8'h12, 1'b0, 1'b0, 4'd0);
    send_cmd(CMD_OR, 6'd63, 8'hff, 1'b0, 1'b0, 4'd0);
    send_cmd(CMD_XOR, 6'd40, 8'h81, 1'b0, 1'b0, 4'd0);
  endtask

  // fill both halves, then the write half only
  task automatic test_fill();
    send_cmd(CMD_FILL, 6'd0, 8'h55, 1'b1, 1'b0, 4'd0);
    send_cmd(CMD_FILL, 6'd63, 8'haa, 1'b0, 1'b1, 4'hf);
    send_cmd(CMD_SET, 6'd1, 8'h00, 1'b0, 1'b0, 4'd0);
  endtask

  // flips, refresh with and without dirty, broadcasts at the extremes
  task automatic test_flip_refresh();
    send_cmd(CMD_FLIP, 6'd0, 8'd0, 1'b0, 1'b0, 4'd0);
    send_cmd(CMD_REFRESH, 6'd0, 8'd0, 1'b0, 1'b0, 4'd0);
    send_cmd(CMD_REFRESH, 6'd0, 8'd0, 1'b0, 1'b0, 4'd0);
    send_cmd(CMD_FLIP, 6'd0, 8'd0, 1'b0, 1'b1, 4'd0);
    send_cmd(CMD_BCAST, 6'd0, 8'hff, 1'b0, 1'b0, 4'hf);
    send_cmd(CMD_BCAST, 6'd63, 8'h00, 1'b1, 1'b1, 4'h0);
  endtask

  // every driver count including zero and the saturating values
  task automatic test_driver_counts();
    logic [2:0] counts [8] = '{3'd1, 3'd0, 3'd7, 3'd2, 3'd5, 3'd3, 3'd6, 3'd4};
    foreach (counts[i]) begin
      write_driver_count(counts[i]);
      repeat (15) send_random();
    end
  endtask

  task automatic test_random_traffic();
    repeat (4) begin
      write_driver_count(3'($urandom_range(0, 7)));
      repeat (40) send_random();
    end
  endtask

  // no stalls on either side
  task automatic test_back_to_back();
    idle_on = 1'b0;
    write_driver_count(3'd4);
    repeat (25) send_random();
    write_driver_count(3'd1);
    repeat (25) send_random();
  endtask

  // main sequence
  initial begin
    foreach (shadow_store[i]) shadow_store[i] = 8'd0;
    shadow_wr_half   = 1'b1;
    shadow_dirty     = 1'b0;
    shadow_ndrv      = 3'd4;
    rst              = 1'b1;
    req.valid        = 1'b0;
    req.cmd          = CMD_SET;
    req.digit_addr   = 6'd0;
    req.value        = 8'd0;
    req.both_buffers = 1'b0;
    req.refresh_now  = 1'b0;
    req.reg_code     = 4'd0;
    cfg.valid        = 1'b0;
    cfg.data         = 3'd0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_digit_writes();
    test_fill();
    test_flip_refresh();
    test_driver_counts();
    test_random_traffic();
    test_back_to_back();
    wait_drain();

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/ldfr_pkg.sv
rtl/ldfr_req_if.sv
rtl/ldfr_rsp_if.sv
rtl/ldfr_cfg_if.sv
rtl/ldfr_ctrl.sv
rtl/ldfr_datapath.sv
rtl/led_digit_frame_refresh_controller.sv
tb/sv/tb_led_digit_frame_refresh_controller.sv
